### sv/grc_pkg.sv
package grc_pkg;

	// Default matrix size and the fixed width of node index fields
	localparam int MAX_NODES_DEF = 64;
	localparam int NODE_W        = 6;

	// Operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Route answers
	localparam logic [1:0] ROUTE_NONE     = 2'd0;
	localparam logic [1:0] ROUTE_DIRECT   = 2'd1;
	localparam logic [1:0] ROUTE_INDIRECT = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] dest_node;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [1:0] route;
	} result_t;

	// Row unit modes
	typedef enum logic [1:0] {
		ALU_SET,
		ALU_CLR,
		ALU_MERGE
	} alu_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ROW_S,
		ST_PIV_RD,
		ST_PIV_WAIT,
		ST_SWEEP,
		ST_FINAL_RD,
		ST_FINAL_CHK
	} state_t;

endpackage

### sv/grc_row_mem.sv
module grc_row_mem
	import grc_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [NW-1:0]        rd_addr,
	output logic [MAX_NODES-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [NW-1:0]        wr_addr,
	input  logic [MAX_NODES-1:0] wr_data
);

	logic [MAX_NODES-1:0] mem [MAX_NODES];
	logic [MAX_NODES-1:0] rd_q;
	logic [MAX_NODES-1:0] row_vld_q;
	logic                 rd_vld_q;

	// Row storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Per-row written flags: an unwritten row reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### sv/grc_row_alu.sv
module grc_row_alu
	import grc_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  alu_mode_t            mode,
	input  logic [MAX_NODES-1:0] row,
	input  logic [MAX_NODES-1:0] pivot,
	input  logic [NW-1:0]        bit_sel,
	output logic [MAX_NODES-1:0] new_row,
	output logic                 sel_bit
);

	assign sel_bit = row[bit_sel];

	// Set, clear, or fold the pivot row in when this row reaches the pivot
	always_comb begin
		new_row = row;
		unique case (mode)
			ALU_SET:   new_row[bit_sel] = 1'b1;
			ALU_CLR:   new_row[bit_sel] = 1'b0;
			ALU_MERGE: new_row = sel_bit ? (row | pivot) : row;
			default:   new_row = row;
		endcase
	end

endmodule

### sv/graph_reachability_closure_core.sv
// Unused codes and bad indices are answered from the decode state; add, remove and a query on a
// direct link are answered from the row state after the source row is read.
// A query that runs the closure sweeps pivots 0..T, T = min(city_count, MAX_NODES-1): for each
// pivot a pivot-row read, a turnaround and a row read-modify-write per row, then a final check.
// One item at a time; busy is high from transfer to result. The receiver cannot stall.
// Reset clears city_count and all row-written flags, so the matrix reads as zero at once.
module graph_reachability_closure_core
	import grc_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              result_strobe,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [NODE_W-1:0] cfg_data
);

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [NODE_W-1:0]    city_q;
	logic [NW-1:0]        k_q, idx_q;
	logic [MAX_NODES-1:0] pivot_q;
	logic [MAX_NODES-1:0] span;
	logic                 strobe_q;
	result_t              result_q;

	logic                 rd_en, wr_en;
	logic [NW-1:0]        rd_addr, wr_addr;
	logic [MAX_NODES-1:0] rd_data, alu_row;
	alu_mode_t            alu_mode;
	logic [NW-1:0]        alu_bit;
	logic                 sel_bit;
	logic                 emit;
	result_t              emit_res;

	logic                 src_ok, dst_ok;
	logic [NW-1:0]        top, src_a, dst_a;

	// Index checks and closure range
	assign src_ok = (cmd_q.source_node != '0) && (cmd_q.source_node <= city_q)
		&& (int'(cmd_q.source_node) < MAX_NODES);
	assign dst_ok = (cmd_q.dest_node != '0) && (cmd_q.dest_node <= city_q)
		&& (int'(cmd_q.dest_node) < MAX_NODES);
	assign top    = (int'(city_q) > MAX_NODES - 1) ? NW'(MAX_NODES - 1) : NW'(city_q);
	assign src_a  = NW'(cmd_q.source_node);
	assign dst_a  = NW'(cmd_q.dest_node);

	// Columns that take part in the closure: 0..top
	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			span[j] = (j <= int'(top));
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	grc_row_mem #(.MAX_NODES(MAX_NODES)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (alu_row)
	);

	grc_row_alu #(.MAX_NODES(MAX_NODES)) u_alu (
		.mode    (alu_mode),
		.row     (rd_data),
		.pivot   (pivot_q),
		.bit_sel (alu_bit),
		.new_row (alu_row),
		.sel_bit (sel_bit)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory and row unit control
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = src_a;
		wr_en    = 1'b0;
		wr_addr  = src_a;
		alu_mode = ALU_MERGE;
		alu_bit  = dst_a;
		emit     = 1'b0;
		emit_res = '{status: 1'b0, route: ROUTE_NONE};
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!(cmd_q.operation == OP_ADD || cmd_q.operation == OP_REMOVE
					|| cmd_q.operation == OP_QUERY)) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else if (!src_ok || !dst_ok) begin
					emit            = 1'b1;
					emit_res.status = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_ROW_S;
				end
			end
			ST_ROW_S: begin
				alu_mode = (cmd_q.operation == OP_ADD) ? ALU_SET : ALU_CLR;
				if (cmd_q.operation != OP_QUERY) begin
					wr_en   = 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else if (sel_bit) begin
					emit           = 1'b1;
					emit_res.route = ROUTE_DIRECT;
					state_d        = ST_IDLE;
				end else begin
					state_d = ST_PIV_RD;
				end
			end
			ST_PIV_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
				state_d = ST_PIV_WAIT;
			end
			ST_PIV_WAIT: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				alu_bit = k_q;
				wr_en   = 1'b1;
				wr_addr = idx_q;
				if (idx_q != top) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 1'b1;
				end else if (k_q == top) begin
					state_d = ST_FINAL_RD;
				end else begin
					state_d = ST_PIV_RD;
				end
			end
			ST_FINAL_RD: begin
				rd_en   = 1'b1;
				state_d = ST_FINAL_CHK;
			end
			ST_FINAL_CHK: begin
				emit           = 1'b1;
				emit_res.route = sel_bit ? ROUTE_INDIRECT : ROUTE_NONE;
				state_d        = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: configuration, strobe, pivot and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_q   <= '0;
			strobe_q <= 1'b0;
			k_q      <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				city_q <= cfg_data;
			end
			strobe_q <= emit;
			if (state_q == ST_ROW_S) begin
				k_q <= '0;
			end else if (state_q == ST_SWEEP && idx_q == top) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == ST_PIV_WAIT) begin
				idx_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Payload registers; pivot row limited to the closure columns
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_PIV_WAIT) begin
			pivot_q <= rd_data & span;
		end
		if (emit) begin
			result_q <= emit_res;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

`ifndef SYNTHESIS
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> state_q == ST_IDLE)
		else $error("result strobe outside idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer did not raise busy");

	a_error_no_route: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.status) |-> result.route == ROUTE_NONE)
		else $error("route set on error result");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_ROW_S || state_q == ST_SWEEP))
		else $error("matrix write outside update states");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> (idx_q <= top && k_q <= top))
		else $error("closure counter beyond range");
`endif

endmodule
